>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define USD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define USD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define USD_ASSERT(label, prop, msg)
`define USD_NEVER(label, cond, msg)

`endif

`endif

>>> sv/usd_pkg.sv
// shared types, constants and helper functions of the utf-8 stream decoder
package usd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] TRAIL_MASK = 8'hC0;
  localparam logic [7:0] TRAIL_TAG  = 8'h80;
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] LEAD2_MIN  = 8'hC0;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT = 8'hF5;

  // one decoded work item handed from the front to the back
  typedef struct packed {
    logic        has_replay;  // lead and taken trails come out as malformed bytes
    logic [7:0]  lead;
    logic [1:0]  seen;
    logic [17:0] payload;
    logic        has_final;   // one more result after any replay
    logic [20:0] cp;
    logic [2:0]  cnt;
    logic        bad;
  } job_t;

  // payload mask of a lead byte by its number of trail bytes
  function automatic logic [7:0] lead_mask(input logic [1:0] trails);
    logic [7:0] m;
    case (trails)
      2'd1:    m = 8'd31;
      2'd2:    m = 8'd15;
      2'd3:    m = 8'd7;
      default: m = 8'd63;
    endcase
    return m;
  endfunction

  // number of trail bytes announced by a lead, 0 when not a usable lead
  function automatic logic [1:0] trails_for_lead(input logic [7:0] b);
    logic [1:0] t;
    if (b < LEAD2_MIN) t = 2'd0;
    else if (b < LEAD3_MIN) t = 2'd1;
    else if (b < LEAD4_MIN) t = 2'd2;
    else if (b < LEAD_LIMIT) t = 2'd3;
    else t = 2'd0;
    return t;
  endfunction

endpackage

>>> sv/usd_queue.sv
// small register queue carrying work items from the front to the back
module usd_queue #(
  parameter int unsigned DEPTH = usd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  usd_pkg::job_t push_data,
  input  logic          pop,
  output usd_pkg::job_t pop_data,
  output logic          full,
  output logic          empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  usd_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/usd_front.sv
// front: takes bytes, tracks the pending sequence and classifies each byte, pushing a work item when a result is due
module usd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  output logic          push,
  output usd_pkg::job_t job
);

  logic [7:0]  lead_r, lead_nxt;
  logic [1:0]  needed_r, needed_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [17:0] pay_r, pay_nxt;

  logic        pending;
  logic        is_trail;
  logic [17:0] new_pay;
  logic [1:0]  seen_inc;
  logic [1:0]  fresh_trails;
  logic [4:0]  lead_shift;

  always_comb begin
    pending      = (needed_r != 2'd0);
    is_trail     = ((in_byte & usd_pkg::TRAIL_MASK) == usd_pkg::TRAIL_TAG);
    new_pay      = {pay_r[11:0], in_byte[5:0]};
    seen_inc     = seen_r + 2'd1;
    fresh_trails = usd_pkg::trails_for_lead(in_byte);
    lead_shift   = 5'd6 * 5'(needed_r);

    job        = '0;
    lead_nxt   = lead_r;
    needed_nxt = needed_r;
    seen_nxt   = seen_r;
    pay_nxt    = pay_r;

    if (pending && is_trail) begin
      pay_nxt  = new_pay;
      seen_nxt = seen_inc;
      if (seen_inc == needed_r) begin
        // sequence complete
        job.has_final = 1'b1;
        job.cp  = (21'(lead_r & usd_pkg::lead_mask(needed_r)) << lead_shift) | 21'(new_pay);
        job.cnt = 3'(needed_r) + 3'd1;
        job.bad = 1'b0;
        lead_nxt   = '0;
        needed_nxt = '0;
        seen_nxt   = '0;
        pay_nxt    = '0;
      end
    end else begin
      if (pending) begin
        // broken sequence: the back replays lead and taken trails
        job.has_replay = 1'b1;
        job.lead       = lead_r;
        job.seen       = seen_r;
        job.payload    = pay_r;
        lead_nxt   = '0;
        needed_nxt = '0;
        seen_nxt   = '0;
        pay_nxt    = '0;
      end
      if (in_byte < usd_pkg::ASCII_TOP) begin
        job.has_final = 1'b1;
        job.cp        = 21'(in_byte);
        job.cnt       = 3'd1;
        job.bad       = 1'b0;
      end else if (fresh_trails == 2'd0) begin
        job.has_final = 1'b1;
        job.cp        = 21'(in_byte);
        job.cnt       = 3'd1;
        job.bad       = 1'b1;
      end else begin
        lead_nxt   = in_byte;
        needed_nxt = fresh_trails;
        seen_nxt   = '0;
        pay_nxt    = '0;
      end
    end

    push = accept && (job.has_replay || job.has_final);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= '0;
      needed_r <= '0;
      seen_r   <= '0;
      pay_r    <= '0;
    end else if (accept) begin
      lead_r   <= lead_nxt;
      needed_r <= needed_nxt;
      seen_r   <= seen_nxt;
      pay_r    <= pay_nxt;
    end
  end

endmodule

>>> sv/usd_back.sv
// back: expands each work item into its result beats behind an output register
module usd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  usd_pkg::job_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [20:0]   out_code_point,
  output logic [2:0]    out_byte_count,
  output logic          out_malformed,
  output logic          out_last
);

  usd_pkg::job_t cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [2:0]    pos_r, pos_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [20:0]   cp_r, cp_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          bad_r, bad_nxt;
  logic          last_r, last_nxt;

  logic          load_out;
  logic [2:0]    total;
  logic          item_last;
  logic [1:0]    diff;
  logic [17:0]   shifted;
  logic [20:0]   item_cp;
  logic [2:0]    item_cnt;
  logic          item_bad;

  always_comb begin
    load_out  = !out_valid_r || !out_stall;
    total     = (cur_r.has_replay ? (3'(cur_r.seen) + 3'd1) : 3'd0) + 3'(cur_r.has_final);
    item_last = (pos_r == total - 3'd1);
    diff      = cur_r.seen - pos_r[1:0];
    shifted   = cur_r.payload >> (5'd6 * 5'(diff));

    // pick the beat at the current position
    if (cur_r.has_replay && pos_r == 3'd0) begin
      item_cp  = 21'(cur_r.lead);
      item_cnt = 3'd1;
      item_bad = 1'b1;
    end else if (cur_r.has_replay && pos_r <= 3'(cur_r.seen)) begin
      item_cp  = 21'({2'b10, shifted[5:0]});
      item_cnt = 3'd1;
      item_bad = 1'b1;
    end else begin
      item_cp  = cur_r.cp;
      item_cnt = cur_r.cnt;
      item_bad = cur_r.bad;
    end

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    cp_nxt        = cp_r;
    cnt_nxt       = cnt_r;
    bad_nxt       = bad_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;

    if (load_out) begin
      out_valid_nxt = cur_valid_r;
      if (cur_valid_r) begin
        cp_nxt   = item_cp;
        cnt_nxt  = item_cnt;
        bad_nxt  = item_bad;
        last_nxt = item_last;
        if (item_last) begin
          cur_valid_nxt = 1'b0;
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end
    end

    if (!cur_valid_nxt && !q_empty) begin
      q_pop         = 1'b1;
      cur_nxt       = q_data;
      cur_valid_nxt = 1'b1;
      pos_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    cp_r   <= cp_nxt;
    cnt_r  <= cnt_nxt;
    bad_r  <= bad_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = cp_r;
  assign out_byte_count = cnt_r;
  assign out_malformed  = bad_r;
  assign out_last       = last_r;

endmodule

>>> sv/utf8_stream_decoder.sv
// top level of the streaming utf-8 decoder
// Takes one utf-8 byte per beat and returns decoded code points, one result beat each, with
// byte_count, a malformed flag and last marking the final beat caused by an input byte. A byte
// is accepted every cycle while the work queue has room; a byte that only extends a pending
// sequence gives no result. Most bytes give one result beat, so the block runs at one byte per
// cycle while out_stall is low. A byte that breaks a pending sequence gives up to four beats
// (the lead and each taken trail replayed as malformed bytes, then the new byte's own result
// unless it is a new lead), and the back end emits one beat per cycle while out_stall is low;
// the queue of QUEUE_DEPTH items absorbs this and input stalls only once the queue fills. A
// pending sequence is only resolved by a later byte, so end a stream with any non-trail byte
// (0x00 for instance) to flush it. Overlong forms and surrogates are not flagged.
`include "assert_macros.svh"

module utf8_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = usd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic [2:0]  out_byte_count,
  output logic        out_malformed,
  output logic        out_last
);

  logic          in_accept;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  usd_pkg::job_t q_wdata;
  usd_pkg::job_t q_rdata;

  // stall purely on queue occupancy so a byte is never lost
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // front: sequence tracking and classification
  usd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_byte (in_byte),
    .push    (q_push),
    .job     (q_wdata)
  );

  // work queue between front and back
  usd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: beat generation and output register
  usd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_byte_count (out_byte_count),
    .out_malformed  (out_malformed),
    .out_last       (out_last)
  );

  // queue status must be consistent
  `USD_NEVER(a_queue_full_empty, q_full && q_empty, "queue full and empty at once")

  // malformed beats carry a single raw byte
  `USD_ASSERT(a_bad_one_byte, out_valid && out_malformed |-> out_byte_count == 3'd1 && out_code_point[20:8] == 13'd0, "malformed beat not a single byte")

  // byte count of any beat stays within one to four
  `USD_ASSERT(a_count_range, out_valid |-> out_byte_count != 3'd0 && out_byte_count <= 3'd4, "byte count out of range")

  // an item popped from the queue always carries at least one beat
  `USD_ASSERT(a_pop_has_beat, q_pop |-> q_rdata.has_replay || q_rdata.has_final, "empty work item in queue")

endmodule
